@@ rtl/core/ffha_pkg.sv @@
`timescale 1ns / 1ps
package ffha_pkg;
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    ACT_ALLOC   = 1'b0,
    ACT_RELEASE = 1'b1
  } action_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_HDR_RD,
    S_HDR_WAIT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_TAIL_RD,
    S_TAIL_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_GAP_RD,
    S_GAP_WR,
    S_PUT,
    S_PREV_RD,
    S_PREV_CHK,
    S_NEXT_RD,
    S_NEXT_CHK,
    S_HDR_WR,
    S_DONE
  } state_t;

  localparam int LEN_W      = 13;
  localparam int ADDR_W     = 12;
  localparam int HEAP_BYTES = 4096;
endpackage

@@ rtl/core/ffha_table.sv @@
`timescale 1ns / 1ps
module ffha_table #(
  parameter int ENTRIES = 64,
  parameter int IDX_W   = 6
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [IDX_W-1:0]         wr_idx,
  input  logic [ffha_pkg::ADDR_W-1:0] wr_start,
  input  logic [ffha_pkg::LEN_W-1:0]  wr_len,
  input  logic [IDX_W-1:0]         rd_idx,
  output logic [ffha_pkg::ADDR_W-1:0] rd_start,
  output logic [ffha_pkg::LEN_W-1:0]  rd_len
);
  logic [ffha_pkg::ADDR_W-1:0] start_mem [ENTRIES];
  logic [ffha_pkg::LEN_W-1:0]  len_mem   [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_mem[wr_idx] <= wr_start;
      len_mem[wr_idx]   <= wr_len;
    end
    rd_start <= start_mem[rd_idx];
    rd_len   <= len_mem[rd_idx];
  end
endmodule

@@ rtl/core/first_fit_heap_allocator.sv @@
`timescale 1ns / 1ps
// From accept to out_tvalid the block walks the free table of n entries, for allocate and
// release alike; a merge or exact fit that removes an entry also shifts later entries down.
// One request at a time: in_tready stays low until the previous result has been taken.
// The steps share the one table memory and the one sum adder of the datapath.
// Reset (rst_n low, synchronous): table empty, break zero, limit 4096.
module first_fit_heap_allocator #(
  parameter int FREE_ENTRIES = 64,
  parameter int HEADER_BYTES = 2,
  parameter int MIN_BLOCK    = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // action[0], request_size[13:1], block_address[25:14]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // status[1:0], granted_address[13:2], block_length[26:14]
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata   // heap_limit
);
  localparam int HEAP_BYTES = ffha_pkg::HEAP_BYTES;
  localparam int LW   = ffha_pkg::LEN_W;
  localparam int AW   = ffha_pkg::ADDR_W;
  localparam int IW   = $clog2(FREE_ENTRIES);
  localparam int CW   = $clog2(FREE_ENTRIES + 1);
  localparam int HW   = $clog2(HEAP_BYTES);
  localparam int WW   = LW + 2;

  ffha_pkg::state_t st_r, st_nxt;
  logic [LW-1:0] limit_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [LW-1:0] brk_r, brk_nxt;
  logic          act_r, act_nxt;
  logic [LW:0]   need_r, need_nxt;
  logic [AW-1:0] s_r, s_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic          rm_r, rm_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic [AW-1:0] oaddr_r, oaddr_nxt;
  logic [LW-1:0] olen_r, olen_nxt;
  logic          ov_r, ov_nxt;

  logic          t_we;
  logic [IW-1:0] t_widx, t_ridx;
  logic [AW-1:0] t_ws, t_rs;
  logic [LW-1:0] t_wl, t_rl;

  ffha_table #(.ENTRIES(FREE_ENTRIES), .IDX_W(IW)) u_table (
    .clk(clk), .wr_en(t_we), .wr_idx(t_widx), .wr_start(t_ws), .wr_len(t_wl),
    .rd_idx(t_ridx), .rd_start(t_rs), .rd_len(t_rl)
  );

  logic [LW-1:0] hdr_mem [HEAP_BYTES];
  logic          h_we;
  logic [HW-1:0] h_idx;
  logic [LW-1:0] h_wd, h_rd;
  always_ff @(posedge clk) begin
    if (h_we) hdr_mem[h_idx] <= h_wd;
    h_rd <= hdr_mem[h_idx];
  end

  logic [LW-1:0] lim;
  assign lim = (32'(limit_r) < HEAP_BYTES) ? limit_r : LW'(HEAP_BYTES);

  logic [WW-1:0] sum_a, sum_b, sum;
  assign sum = sum_a + sum_b;

  logic [LW-1:0] rq;
  logic [WW-1:0] nd;
  assign rq = in_tdata[13:1];
  assign nd = WW'(rq) + WW'(HEADER_BYTES);

  assign in_tready = (st_r == ffha_pkg::S_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata = {5'd0, olen_r, oaddr_r, stat_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ffha_pkg::S_IDLE;
      limit_r <= LW'(4096);
      cnt_r <= '0;
      brk_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) limit_r <= cfg_wdata;
      cnt_r <= cnt_nxt;
      brk_r <= brk_nxt;
      ov_r <= ov_nxt;
    end
    act_r <= act_nxt; need_r <= need_nxt; s_r <= s_nxt; len_r <= len_nxt;
    k_r <= k_nxt; j_r <= j_nxt; rm_r <= rm_nxt; stat_r <= stat_nxt;
    oaddr_r <= oaddr_nxt; olen_r <= olen_nxt;
  end

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; brk_nxt = brk_r; ov_nxt = ov_r;
    act_nxt = act_r; need_nxt = need_r; s_nxt = s_r; len_nxt = len_r;
    k_nxt = k_r; j_nxt = j_r; rm_nxt = rm_r; stat_nxt = stat_r;
    oaddr_nxt = oaddr_r; olen_nxt = olen_r;
    t_we = 1'b0; t_widx = '0; t_ws = s_r; t_wl = len_r;
    t_ridx = IW'(k_r);
    h_we = 1'b0; h_idx = HW'(s_r); h_wd = LW'(need_r);
    sum_a = '0; sum_b = '0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (st_r)
      ffha_pkg::S_IDLE: begin
        if (in_tvalid && in_tready) begin
          act_nxt = in_tdata[0];
          stat_nxt = ffha_pkg::ST_OK;
          oaddr_nxt = '0; olen_nxt = '0;
          k_nxt = '0;
          need_nxt = (nd < WW'(MIN_BLOCK)) ? (LW+1)'(MIN_BLOCK) : (LW+1)'(nd);
          s_nxt = AW'(in_tdata[25:14] - AW'(HEADER_BYTES % HEAP_BYTES));
          if (in_tdata[0] == ffha_pkg::ACT_RELEASE) begin
            if (32'(cnt_r) >= FREE_ENTRIES) begin
              stat_nxt = ffha_pkg::ST_FULL;
              st_nxt = ffha_pkg::S_DONE;
            end else st_nxt = ffha_pkg::S_HDR_RD;
          end else st_nxt = ffha_pkg::S_SCAN_RD;
        end
      end
      ffha_pkg::S_HDR_RD: begin
        st_nxt = ffha_pkg::S_HDR_WAIT;
      end
      ffha_pkg::S_HDR_WAIT: begin
        len_nxt = (32'(s_r) < HEAP_BYTES) ? h_rd : '0;
        olen_nxt = (32'(s_r) < HEAP_BYTES) ? h_rd : '0;
        st_nxt = ffha_pkg::S_SCAN_RD;
      end
      ffha_pkg::S_SCAN_RD: begin
        if (k_r >= cnt_r) begin
          if (act_r == ffha_pkg::ACT_RELEASE) begin
            j_nxt = cnt_r;
            st_nxt = ffha_pkg::S_GAP_RD;
          end else if (cnt_r != '0) begin
            k_nxt = cnt_r - 1'b1;
            st_nxt = ffha_pkg::S_TAIL_RD;
          end else begin
            sum_a = WW'(brk_r); sum_b = WW'(need_r);
            if (sum > WW'(lim)) begin
              stat_nxt = ffha_pkg::ST_OOM;
              st_nxt = ffha_pkg::S_DONE;
            end else begin
              s_nxt = AW'(brk_r);
              brk_nxt = LW'(sum);
              st_nxt = ffha_pkg::S_HDR_WR;
            end
          end
        end else st_nxt = ffha_pkg::S_SCAN_CHK;
      end
      ffha_pkg::S_SCAN_CHK: begin
        if (act_r == ffha_pkg::ACT_RELEASE) begin
          if (s_r <= t_rs) begin
            j_nxt = cnt_r;
            st_nxt = ffha_pkg::S_GAP_RD;
          end else begin
            k_nxt = k_r + 1'b1;
            st_nxt = ffha_pkg::S_SCAN_RD;
          end
        end else if ({1'b0, t_rl} >= need_r) begin
          s_nxt = t_rs;
          sum_a = WW'(need_r); sum_b = WW'(MIN_BLOCK);
          if (WW'(t_rl) >= sum) begin
            t_we = 1'b1; t_widx = IW'(k_r);
            t_ws = t_rs + AW'(need_r);
            t_wl = t_rl - LW'(need_r);
            st_nxt = ffha_pkg::S_HDR_WR;
          end else begin
            need_nxt = {1'b0, t_rl};
            j_nxt = k_r;
            st_nxt = ffha_pkg::S_SHIFT_RD;
          end
        end else begin
          k_nxt = k_r + 1'b1;
          st_nxt = ffha_pkg::S_SCAN_RD;
        end
      end
      ffha_pkg::S_TAIL_RD: st_nxt = ffha_pkg::S_TAIL_CHK;
      ffha_pkg::S_TAIL_CHK: begin
        if (LW'(WW'(t_rs) + WW'(t_rl)) == brk_r &&
            (WW'(t_rs) + WW'(t_rl)) == WW'(brk_r)) begin
          sum_a = WW'(t_rs); sum_b = WW'(need_r);
          if (sum > WW'(lim)) begin
            stat_nxt = ffha_pkg::ST_OOM;
            st_nxt = ffha_pkg::S_DONE;
          end else begin
            s_nxt = t_rs;
            brk_nxt = LW'(sum);
            cnt_nxt = cnt_r - 1'b1;
            st_nxt = ffha_pkg::S_HDR_WR;
          end
        end else begin
          sum_a = WW'(brk_r); sum_b = WW'(need_r);
          if (sum > WW'(lim)) begin
            stat_nxt = ffha_pkg::ST_OOM;
            st_nxt = ffha_pkg::S_DONE;
          end else begin
            s_nxt = AW'(brk_r);
            brk_nxt = LW'(sum);
            st_nxt = ffha_pkg::S_HDR_WR;
          end
        end
      end
      // remove entry j_r by shifting down
      ffha_pkg::S_SHIFT_RD: begin
        if (j_r + 1'b1 >= cnt_r) begin
          cnt_nxt = cnt_r - 1'b1;
          if (act_r == ffha_pkg::ACT_RELEASE) st_nxt = rm_r ? ffha_pkg::S_NEXT_RD
                                                           : ffha_pkg::S_DONE;
          else st_nxt = ffha_pkg::S_HDR_WR;
        end else begin
          t_ridx = IW'(j_r + 1'b1);
          st_nxt = ffha_pkg::S_SHIFT_WR;
        end
      end
      ffha_pkg::S_SHIFT_WR: begin
        t_we = 1'b1; t_widx = IW'(j_r); t_ws = t_rs; t_wl = t_rl;
        j_nxt = j_r + 1'b1;
        st_nxt = ffha_pkg::S_SHIFT_RD;
      end
      // open a slot at k_r by shifting up
      ffha_pkg::S_GAP_RD: begin
        if (j_r <= k_r) st_nxt = ffha_pkg::S_PUT;
        else begin
          t_ridx = IW'(j_r - 1'b1);
          st_nxt = ffha_pkg::S_GAP_WR;
        end
      end
      ffha_pkg::S_GAP_WR: begin
        t_we = 1'b1; t_widx = IW'(j_r); t_ws = t_rs; t_wl = t_rl;
        j_nxt = j_r - 1'b1;
        st_nxt = ffha_pkg::S_GAP_RD;
      end
      ffha_pkg::S_PUT: begin
        t_we = 1'b1; t_widx = IW'(k_r); t_ws = s_r; t_wl = len_r;
        cnt_nxt = cnt_r + 1'b1;
        if (k_r != '0) begin
          st_nxt = ffha_pkg::S_PREV_RD;
        end else st_nxt = ffha_pkg::S_NEXT_RD;
      end
      ffha_pkg::S_PREV_RD: begin
        t_ridx = IW'(k_r - 1'b1);
        st_nxt = ffha_pkg::S_PREV_CHK;
      end
      ffha_pkg::S_PREV_CHK: begin
        sum_a = WW'(t_rs); sum_b = WW'(t_rl);
        if (sum == WW'(s_r)) begin
          t_we = 1'b1; t_widx = IW'(k_r - 1'b1); t_ws = t_rs;
          t_wl = t_rl + len_r;
          s_nxt = t_rs; len_nxt = t_rl + len_r;
          j_nxt = k_r; k_nxt = k_r - 1'b1; rm_nxt = 1'b1;
          st_nxt = ffha_pkg::S_SHIFT_RD;
        end else st_nxt = ffha_pkg::S_NEXT_RD;
      end
      ffha_pkg::S_NEXT_RD: begin
        rm_nxt = 1'b0;
        if (k_r + 1'b1 >= cnt_r) st_nxt = ffha_pkg::S_DONE;
        else begin
          t_ridx = IW'(k_r + 1'b1);
          st_nxt = ffha_pkg::S_NEXT_CHK;
        end
      end
      ffha_pkg::S_NEXT_CHK: begin
        sum_a = WW'(s_r); sum_b = WW'(len_r);
        if (sum == WW'(t_rs)) begin
          t_we = 1'b1; t_widx = IW'(k_r); t_ws = s_r; t_wl = len_r + t_rl;
          j_nxt = k_r + 1'b1;
          st_nxt = ffha_pkg::S_SHIFT_RD;
        end else st_nxt = ffha_pkg::S_DONE;
      end
      ffha_pkg::S_HDR_WR: begin
        h_we = 32'(s_r) < HEAP_BYTES;
        oaddr_nxt = s_r + AW'(HEADER_BYTES);
        olen_nxt = LW'(need_r);
        st_nxt = ffha_pkg::S_DONE;
      end
      ffha_pkg::S_DONE: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          st_nxt = ffha_pkg::S_IDLE;
        end
      end
      default: st_nxt = ffha_pkg::S_IDLE;
    endcase
    if (st_r == ffha_pkg::S_IDLE) rm_nxt = 1'b0;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= FREE_ENTRIES) else $error("free count overflow");
  a_brk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    brk_nxt != brk_r |-> 32'(brk_nxt) <= HEAP_BYTES) else $error("break past heap");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("accepted while busy");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ffha_pkg::ST_OK |-> out_tdata[26:2] == '0)
    else $error("failure carries data");
endmodule
